>>> src/rvm_pkg.sv
// Shared constants, operation codes and cell control types for the row-vector matrix multiply.
package rvm_pkg;

  // Matrix order: B is N by N, the A row holds N elements.
  localparam int N = 8;
  localparam int IDX_W = $clog2(N);

  // Fixed field widths of the channel words.
  localparam int OP_W   = 2;
  localparam int FIDX_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_B  = 2'd0,
    OP_LOAD_A  = 2'd1,
    OP_COMPUTE = 2'd2
  } op_t;

  // Broadcast control for every cell of the chain.
  typedef struct packed {
    logic             mul_en;  // multiply data by entry addr
    logic             first;   // first term of a dot product: restart the sum
    logic             shift;   // move sums one cell toward the output
    logic [IDX_W-1:0] addr;    // B row: write address on loads, read address on MACs
  } cell_ctrl_t;

endpackage

>>> src/rvm_in_if.sv
// Input channel: valid/ready handshake carrying one operation word.
interface rvm_in_if;
  import rvm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic [FIDX_W-1:0]         row_index;
  logic [FIDX_W-1:0]         col_index;
  logic signed [DATA_W-1:0]  value;

  modport source (output valid, operation, row_index, col_index, value, input ready);
  modport sink   (input valid, operation, row_index, col_index, value, output ready);
endinterface

>>> src/rvm_out_if.sv
// Result channel: valid/ready handshake carrying one dot product word.
interface rvm_out_if;
  import rvm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FIDX_W-1:0]         out_row;
  logic [FIDX_W-1:0]         out_col;
  logic signed [DATA_W-1:0]  dot_product;
  logic                      last_result;

  modport source (output valid, out_row, out_col, dot_product, last_result, input ready);
  modport sink   (input valid, out_row, out_col, dot_product, last_result, output ready);
endinterface

>>> src/rvm_cell.sv
// One column cell: holds a column of B, a multiplier, an accumulator and a shift stage.
module rvm_cell
  import rvm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic              we,
  input  logic [DATA_W-1:0] data,
  input  logic [DATA_W-1:0] shift_in,
  output logic [DATA_W-1:0] acc_out
);

  logic [DATA_W-1:0] b_col_r [N];
  logic [DATA_W-1:0] b_rd;
  logic [DATA_W-1:0] prod_r;
  logic [DATA_W-1:0] prod_nxt;
  logic [DATA_W-1:0] acc_r;
  logic              mac_vld_r;
  logic              first_r;

  assign b_rd     = b_col_r[ctrl.addr];
  // keep the low word only: the sum wraps modulo 2^32
  assign prod_nxt = data * b_rd;
  assign acc_out  = acc_r;

  always_ff @(posedge clk) begin
    if (we) begin
      b_col_r[ctrl.addr] <= data;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_vld_r <= 1'b0;
      first_r   <= 1'b0;
    end else begin
      mac_vld_r <= ctrl.mul_en;
      first_r   <= ctrl.first;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_vld_r) begin
      acc_r <= first_r ? prod_r : acc_r + prod_r;
    end else if (ctrl.shift) begin
      acc_r <= shift_in;
    end
  end

endmodule

>>> src/row_vector_matrix_multiply.sv
// Top level of the row-vector by matrix multiply: sequencer, A row store and the cell chain.
//
// The block holds an N by N integer matrix B and one row vector A (N = 8). Each of the
// N cells owns one column of B and its own 32x32 multiplier and accumulator. A load-B
// word writes one element into the cell of its column, a load-A word writes one element
// of the A row; either gives no result. A compute word broadcasts A[0..N-1] to all
// cells in turn, so every column is summed at once, passes through a flush state while
// the last product lands in the accumulators, then shifts the N sums out of cell 0
// through the chain in ascending column order, one result word per cycle while the sink
// is ready. A compute word therefore holds the input off through the broadcast, the
// flush and the drain, which any stall on the result side lengthens; the cost is set by
// the N-step broadcast of the A row and the N-word drain of the shift chain. New words
// are taken only while the block is idle. Operation code 3 and out-of-range indexes are
// dropped. Products and sums wrap modulo 2^32. Entries of B or A that were never written
// read as unknown values.
module row_vector_matrix_multiply
  import rvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rvm_in_if.sink     in_chan,
  rvm_out_if.source  out_chan
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_OUT
  } state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  cnt_r;
  logic [FIDX_W-1:0] row_tag_r;
  logic [DATA_W-1:0] a_row_r [N];

  logic              in_acc;
  logic              cnt_last;
  logic              load_b_ok;
  logic              load_a_ok;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data;
  logic [N-1:0]      cell_we;
  logic [DATA_W-1:0] acc [N];

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cnt_last      = (cnt_r == IDX_W'(N - 1));

  // range checks matter only when N is below what the index fields can address
  assign load_b_ok = in_acc && (in_chan.operation == OP_LOAD_B) &&
                     (int'(in_chan.row_index) < N) && (int'(in_chan.col_index) < N);
  assign load_a_ok = in_acc && (in_chan.operation == OP_LOAD_A) &&
                     (int'(in_chan.col_index) < N);

  // Broadcast control: in S_MAC the cells read B row cnt_r, loads write B row row_index.
  always_comb begin
    ctrl.mul_en = (state_r == S_MAC);
    ctrl.first  = (cnt_r == '0);
    ctrl.shift  = (state_r == S_OUT) && out_chan.ready;
    ctrl.addr   = (state_r == S_MAC) ? cnt_r : IDX_W'(in_chan.row_index);
    cell_data   = (state_r == S_MAC) ? a_row_r[cnt_r] : $unsigned(in_chan.value);
  end

  // Sequencer: hold in idle, step the A row through the cells, flush, drain the sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (in_acc && (in_chan.operation == OP_COMPUTE)) begin
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_last) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // last product lands in the accumulators this cycle
          cnt_r   <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_chan.ready) begin
            cnt_r <= cnt_r + 1'b1;
            if (cnt_last) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: row tag of the compute word and the A row store.
  always_ff @(posedge clk) begin
    if (in_acc && (in_chan.operation == OP_COMPUTE)) begin
      row_tag_r <= in_chan.row_index;
    end
    if (load_a_ok) begin
      a_row_r[IDX_W'(in_chan.col_index)] <= $unsigned(in_chan.value);
    end
  end

  // Column cells; sums move toward cell 0, the last cell takes in zero.
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [DATA_W-1:0] shift_in;

    assign cell_we[k] = load_b_ok && (IDX_W'(in_chan.col_index) == IDX_W'(k));

    if (k == N - 1) begin : g_tail
      assign shift_in = '0;
    end else begin : g_link
      assign shift_in = acc[k+1];
    end

    rvm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .we       (cell_we[k]),
      .data     (cell_data),
      .shift_in (shift_in),
      .acc_out  (acc[k])
    );
  end

  // Result word straight from the head of the chain.
  assign out_chan.valid       = (state_r == S_OUT);
  assign out_chan.out_row     = row_tag_r;
  assign out_chan.out_col     = FIDX_W'(cnt_r);
  assign out_chan.dot_product = $signed(acc[0]);
  assign out_chan.last_result = cnt_last;

endmodule

>>> test/row_vector_matrix_multiply_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for row_vector_matrix_multiply: directed table, random words, column scoreboard.
module row_vector_matrix_multiply_tb;
  import rvm_pkg::*;

  // Operation code 3 has no meaning; the block must drop it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 16;
  localparam int HOLD_CYCLES  = 200;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 40;   // margin after the last owed column, longer than a compute occupies the block
  localparam int NUM_DIRECTED = 24;

  // One expected result word: one column of the row-vector product.
  typedef struct packed {
    logic [FIDX_W-1:0] row;
    logic [FIDX_W-1:0] col;
    logic [DATA_W-1:0] dot;
    logic              last;
  } column_result_t;

  // One row of the directed table. Where known is set, every column of a compute
  // is expected to equal known_dot; otherwise the shadow model supplies the sums.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [FIDX_W-1:0] row;
    logic [FIDX_W-1:0] col;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] known_dot;
  } table_word_t;

  logic clk;
  logic rst_n;

  rvm_in_if  in_chan ();
  rvm_out_if out_chan ();

  row_vector_matrix_multiply u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copies of the B matrix and the A row, updated as words are accepted.
  logic [DATA_W-1:0] b_shadow [N][N];
  logic [DATA_W-1:0] a_shadow [N];

  // Columns still owed by the block, oldest first.
  column_result_t pending_columns [$];

  int error_count = 0;
  bit steady       = 1'b0;  // set: neither side idles
  bit hold_request = 1'b0;  // set: receiver starts its long hold-off

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Wrapping 32-bit dot product of the A row with column k of B.
  function automatic logic [DATA_W-1:0] column_dot(input int k);
    logic [DATA_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < N; i++) acc = acc + a_shadow[i] * b_shadow[i][k];
    return acc;
  endfunction

  // Element values, biased toward the corners of the signed range.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Offer one word, hold it until accepted, then advance the shadow state and
  // queue the columns a compute owes. Outside the steady stretch, random idle cycles go in ahead of the word.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [FIDX_W-1:0] row,
                           input logic [FIDX_W-1:0] col, input logic [DATA_W-1:0] value,
                           input logic known, input logic [DATA_W-1:0] known_dot);
    column_result_t col_result;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 27) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.row_index <= row;
    in_chan.col_index <= col;
    in_chan.value     <= value;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    case (op)
      OP_LOAD_B: begin
        if (row < N && col < N) b_shadow[row][col] = value;
      end
      OP_LOAD_A: begin
        if (col < N) a_shadow[col] = value;
      end
      OP_COMPUTE: begin
        for (int k = 0; k < N; k++) begin
          col_result.row  = row;
          col_result.col  = FIDX_W'(k);
          col_result.dot  = known ? known_dot : column_dot(k);
          col_result.last = (k == N - 1);
          pending_columns.push_back(col_result);
        end
      end
      default: ;  // unused code: drop, no state change
    endcase
  endtask

  // Receiver: random stalls, a steady stretch, and one long hold-off on request.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  // Scoreboard: compare each accepted result word with the oldest owed column.
  always @(posedge clk) begin
    column_result_t want;
    if (rst_n && $isunknown(out_chan.valid)) begin
      $error("valid: expected a known level, actual %b", out_chan.valid);
      error_count++;
    end
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (pending_columns.size() == 0) begin
        $error("unexpected result word: row %0d col %0d dot %0h", out_chan.out_row,
               out_chan.out_col, out_chan.dot_product);
        error_count++;
      end else begin
        want = pending_columns.pop_front();
        if (out_chan.out_row !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, out_chan.out_row);
          error_count++;
        end
        if (out_chan.out_col !== want.col) begin
          $error("out_col: expected %0d, actual %0d", want.col, out_chan.out_col);
          error_count++;
        end
        if (out_chan.dot_product !== want.dot) begin
          $error("dot_product: expected %0h, actual %0h", want.dot, out_chan.dot_product);
          error_count++;
        end
        if (out_chan.last_result !== want.last) begin
          $error("last_result: expected %0d, actual %0d", want.last, out_chan.last_result);
          error_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    table_word_t directed_words [NUM_DIRECTED];
    int taken;
    int pick;

    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_LOAD_B;
    in_chan.row_index = '0;
    in_chan.col_index = '0;
    in_chan.value     = '0;

    directed_words = '{
      // Clear the A row, both ends of the index range included.
      '{OP_LOAD_A,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd7, 3'd1, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd2, 3'd2, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd5, 3'd3, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd1, 3'd4, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd6, 3'd5, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd3, 3'd6, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd4, 3'd7, 32'h0000_0000, 1'b0, 32'h0},
      // Zero A row: every column sums to zero whatever B holds.
      '{OP_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h0},
      // Unused code with all ones: must change nothing and give nothing.
      '{OP_UNUSED,  3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
      // Extreme operands: max times min and max squared wrap.
      '{OP_LOAD_A,  3'd0, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{OP_LOAD_B,  3'd7, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_LOAD_B,  3'd7, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0},
      '{OP_LOAD_B,  3'd0, 3'd3, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd7, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_LOAD_B,  3'd0, 3'd7, 32'h8000_0000, 1'b0, 32'h0},
      '{OP_COMPUTE, 3'd3, 3'd4, 32'h5A5A_A5A5, 1'b0, 32'h0},
      // A row of minus one in front: results are negated B row 0.
      '{OP_LOAD_A,  3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd0, 3'd7, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_COMPUTE, 3'd5, 3'd2, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_UNUSED,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_LOAD_A,  3'd2, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
      '{OP_COMPUTE, 3'd6, 3'd1, 32'h0000_0000, 1'b1, 32'h0}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Write every entry of B and of the A row before any compute reads them.
    for (int r = 0; r < N; r++) begin
      for (int c = 0; c < N; c++) begin
        send_word(OP_LOAD_B, FIDX_W'(r), FIDX_W'(c), pick_value(), 1'b0, '0);
      end
    end
    for (int c = 0; c < N; c++) begin
      send_word(OP_LOAD_A, FIDX_W'($urandom_range(7)), FIDX_W'(c), pick_value(), 1'b0, '0);
    end

    // Steady stretch: neither side idles through the directed table.
    steady = 1'b1;
    foreach (directed_words[n]) begin
      send_word(directed_words[n].op, directed_words[n].row, directed_words[n].col,
                directed_words[n].value, directed_words[n].known, directed_words[n].known_dot);
    end
    steady = 1'b0;

    // Random mix: mostly loads that reshape B and A between computes, some noise.
    // Dropped words do not advance the count.
    taken = 0;
    while (taken < RANDOM_WORDS) begin
      // Force a run of computes while the receiver holds off, so input stalls.
      pick = (taken >= 2 && taken < 6) ? 0 : $urandom_range(99);
      if (pick < 25) begin
        send_word(OP_COMPUTE, FIDX_W'($urandom_range(7)), FIDX_W'($urandom_range(7)),
                  $urandom, 1'b0, '0);
      end else if (pick < 30) begin
        send_word(OP_UNUSED, FIDX_W'($urandom_range(7)), FIDX_W'($urandom_range(7)),
                  $urandom, 1'b0, '0);
      end else if (pick < 65) begin
        send_word(OP_LOAD_B, FIDX_W'($urandom_range(7)), FIDX_W'($urandom_range(7)),
                  pick_value(), 1'b0, '0);
      end else begin
        send_word(OP_LOAD_A, FIDX_W'($urandom_range(7)), FIDX_W'($urandom_range(7)),
                  pick_value(), 1'b0, '0);
      end
      if (pick >= 25 && pick < 30) continue;
      taken++;
      if (taken == 2) hold_request = 1'b1;
      if (taken == 10) begin
        // Pause the sender until the block has delivered everything owed.
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (pending_columns.size() != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
